// File: src/twr_pkg.sv
// shared constants and payload types for the two-channel window rms unit
`timescale 1ns / 1ps
package twr_pkg;

  localparam int WINDOW      = 64;
  localparam int SAMPLE_BITS = 12;

  localparam int FIELD_W    = 12;
  localparam int OUT_W      = 12;
  localparam logic [FIELD_W-1:0] DC_RESET = 12'd2048;

  localparam int POS_W      = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int ADDR_W     = POS_W + 1;
  localparam int RING_DEPTH = 2 ** ADDR_W;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int SUM_W      = SQ_W + $clog2(WINDOW);
  localparam int RT_W       = SAMPLE_BITS;
  localparam int STEP_W     = $clog2(SUM_W);

  // remainder and alu widths shared by the divide and root steps
  localparam int REM_W = (CNT_W > RT_W + 2) ? CNT_W : RT_W + 2;
  localparam int ALU_W = (CNT_W + 1 > RT_W + 3) ? CNT_W + 1 : RT_W + 3;

  typedef struct packed {
    logic               req_type;
    logic               channel;
    logic [FIELD_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] rms_first;
    logic [OUT_W-1:0] rms_second;
  } out_t;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

endpackage

// File: src/twr_ring.sv
// ring store of squared samples for both channels, one write and one registered read
`timescale 1ns / 1ps
module twr_ring (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [twr_pkg::ADDR_W-1:0] wr_addr,
  input  logic [twr_pkg::SQ_W-1:0]   wr_data,
  input  logic [twr_pkg::ADDR_W-1:0] rd_addr,
  output logic [twr_pkg::SQ_W-1:0]   rd_data
);

  logic [twr_pkg::SQ_W-1:0] mem [twr_pkg::RING_DEPTH];
  logic [twr_pkg::SQ_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/twr_calc.sv
// shared subtract unit: restoring divide of the window sum, then floor square root
`timescale 1ns / 1ps
module twr_calc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [twr_pkg::SUM_W-1:0] sum_in,
  input  logic [twr_pkg::CNT_W-1:0] div_in,
  output logic                      done,
  output logic [twr_pkg::RT_W-1:0]  root
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_SQRT = 2'd2;
  localparam logic [1:0] P_DONE = 2'd3;

  logic [1:0]                  phase_r, phase_nxt;
  logic [twr_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [twr_pkg::SUM_W-1:0]   quo_r, quo_nxt;
  logic [twr_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [twr_pkg::CNT_W-1:0]   div_r, div_nxt;
  logic [twr_pkg::RT_W-1:0]    root_r, root_nxt;

  logic [twr_pkg::ALU_W-1:0]   op_a, op_b;
  logic [twr_pkg::ALU_W:0]     diff;
  logic                        ge;
  logic [twr_pkg::CNT_W:0]     rem_sh;
  logic [twr_pkg::RT_W+2:0]    rem_t;
  logic [twr_pkg::RT_W+2:0]    trial;

  always_comb begin
    rem_sh = {rem_r[twr_pkg::CNT_W-1:0], quo_r[twr_pkg::SUM_W-1]};
    rem_t  = {rem_r[twr_pkg::RT_W:0], quo_r[twr_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    if (phase_r == P_SQRT) begin
      op_a = twr_pkg::ALU_W'(rem_t);
      op_b = twr_pkg::ALU_W'(trial);
    end else begin
      op_a = twr_pkg::ALU_W'(rem_sh);
      op_b = twr_pkg::ALU_W'(div_r);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[twr_pkg::ALU_W];
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    root_nxt  = root_r;
    unique case (phase_r)
      P_IDLE: begin
        if (start) begin
          quo_nxt   = sum_in;
          rem_nxt   = '0;
          div_nxt   = div_in;
          cnt_nxt   = '0;
          phase_nxt = P_DIV;
        end
      end
      P_DIV: begin
        // one quotient bit a cycle, dividend shifts out as quotient shifts in
        quo_nxt = {quo_r[twr_pkg::SUM_W-2:0], ge};
        rem_nxt = ge ? twr_pkg::REM_W'(diff) : twr_pkg::REM_W'(rem_sh);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == twr_pkg::STEP_W'(twr_pkg::SUM_W - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          phase_nxt = P_SQRT;
        end
      end
      P_SQRT: begin
        // two radicand bits a cycle, quotient fits below SQ_W bits
        quo_nxt  = {quo_r[twr_pkg::SUM_W-3:0], 2'b00};
        rem_nxt  = ge ? twr_pkg::REM_W'(diff) : twr_pkg::REM_W'(rem_t);
        root_nxt = {root_r[twr_pkg::RT_W-2:0], ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == twr_pkg::STEP_W'(twr_pkg::RT_W - 1)) begin
          phase_nxt = P_DONE;
        end
      end
      P_DONE: begin
        phase_nxt = P_IDLE;
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    root_r <= root_nxt;
  end

  assign done = (phase_r == P_DONE);
  assign root = root_r;

endmodule

// File: src/two_channel_window_rms_unit.sv
// top level: sample path, ring update, read sequencer and result register
`timescale 1ns / 1ps
// Level meter for two channels. A sample item (req_type 0) takes the absolute
// difference of the sample from dc_reference, squares it and adds it to that
// channel's sliding window of the last WINDOW squares; it produces no result
// and passes through the square and ring read, then the sum and ring update. A read
// item (req_type 1) returns the floor square root of each channel's window
// mean, dividing by the samples held so far until the window has filled, and
// 0 for a channel with no samples. Both channels go one after the other
// through one shared subtract unit that does a restoring divide, one bit a
// cycle, then the root, two radicand bits a cycle; a channel that is still empty
// skips the unit. The ring needs no clearing after reset. A result waits in its
// output register while further sample items are taken.
module two_channel_window_rms_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  twr_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output twr_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [twr_pkg::FIELD_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SMP    = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_PEND   = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [twr_pkg::FIELD_W-1:0] dc_r, dc_nxt;
  logic [twr_pkg::POS_W-1:0]   pos0_r, pos0_nxt, pos1_r, pos1_nxt;
  logic                        full0_r, full0_nxt, full1_r, full1_nxt;
  logic [twr_pkg::SUM_W-1:0]   sum0_r, sum0_nxt, sum1_r, sum1_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        rd_ch_r, rd_ch_nxt;
  logic                        ch_r, ch_nxt;
  logic [twr_pkg::SQ_W-1:0]    sq_r, sq_nxt;
  logic [twr_pkg::RT_W-1:0]    res0_r, res0_nxt, res1_r, res1_nxt;
  twr_pkg::out_t               out_data_r, out_data_nxt;

  logic                          accept;
  logic [twr_pkg::SAMPLE_BITS-1:0] smp, dc_ref, absdiff;
  logic [twr_pkg::SQ_W-1:0]      sq_c;
  logic [twr_pkg::POS_W-1:0]     pos_in, pos_c, pos_new, pos_rd;
  logic                          full_c, full_rd;
  logic [twr_pkg::SUM_W-1:0]     sum_c, sum_new, sum_rd;
  logic [twr_pkg::SQ_W-1:0]      old_sq;
  logic [twr_pkg::CNT_W-1:0]     calc_n;
  logic                          calc_start, calc_done;
  logic [twr_pkg::RT_W-1:0]      calc_root;
  logic                          slot_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // sample path: absolute difference and square
  always_comb begin
    smp     = in_data.sample[twr_pkg::SAMPLE_BITS-1:0];
    dc_ref  = dc_r[twr_pkg::SAMPLE_BITS-1:0];
    absdiff = (smp > dc_ref) ? (smp - dc_ref) : (dc_ref - smp);
    sq_c    = twr_pkg::SQ_W'(absdiff) * twr_pkg::SQ_W'(absdiff);
  end

  always_comb begin
    pos_in  = in_data.channel ? pos1_r : pos0_r;
    pos_c   = ch_r ? pos1_r : pos0_r;
    full_c  = ch_r ? full1_r : full0_r;
    sum_c   = ch_r ? sum1_r : sum0_r;
    // the old entry only counts once the ring has wrapped
    sum_new = full_c ? (sum_c - twr_pkg::SUM_W'(old_sq) + twr_pkg::SUM_W'(sq_r))
                     : (sum_c + twr_pkg::SUM_W'(sq_r));
    pos_new = (pos_c == twr_pkg::POS_W'(twr_pkg::WINDOW - 1)) ? '0 : pos_c + 1'b1;
    pos_rd  = rd_ch_r ? pos1_r : pos0_r;
    full_rd = rd_ch_r ? full1_r : full0_r;
    sum_rd  = rd_ch_r ? sum1_r : sum0_r;
    calc_n  = full_rd ? twr_pkg::CNT_W'(twr_pkg::WINDOW) : twr_pkg::CNT_W'(pos_rd);
    calc_start = (state_r == S_LAUNCH) && (calc_n != '0);
    slot_free  = !out_valid_r || out_ready;
  end

  twr_ring u_ring (
    .clk     (clk),
    .wr_en   (state_r == S_SMP),
    .wr_addr ({ch_r, pos_c}),
    .wr_data (sq_r),
    .rd_addr ({in_data.channel, pos_in}),
    .rd_data (old_sq)
  );

  twr_calc u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (calc_start),
    .sum_in (sum_rd),
    .div_in (calc_n),
    .done   (calc_done),
    .root   (calc_root)
  );

  always_comb begin
    state_nxt     = state_r;
    dc_nxt        = cfg_valid ? cfg_data : dc_r;
    pos0_nxt      = pos0_r;
    pos1_nxt      = pos1_r;
    full0_nxt     = full0_r;
    full1_nxt     = full1_r;
    sum0_nxt      = sum0_r;
    sum1_nxt      = sum1_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_ch_nxt     = rd_ch_r;
    ch_nxt        = ch_r;
    sq_nxt        = sq_r;
    res0_nxt      = res0_r;
    res1_nxt      = res1_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == twr_pkg::REQ_SAMPLE) begin
            ch_nxt    = in_data.channel;
            sq_nxt    = sq_c;
            state_nxt = S_SMP;
          end else begin
            rd_ch_nxt = 1'b0;
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_SMP: begin
        if (ch_r) begin
          sum1_nxt = sum_new;
          pos1_nxt = pos_new;
          if (pos_new == '0) full1_nxt = 1'b1;
        end else begin
          sum0_nxt = sum_new;
          pos0_nxt = pos_new;
          if (pos_new == '0) full0_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_LAUNCH: begin
        if (calc_n == '0) begin
          // empty channel reads as zero
          if (rd_ch_r) begin
            res1_nxt  = '0;
            state_nxt = S_PEND;
          end else begin
            res0_nxt  = '0;
            rd_ch_nxt = 1'b1;
          end
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (calc_done) begin
          if (rd_ch_r) begin
            res1_nxt  = calc_root;
            state_nxt = S_PEND;
          end else begin
            res0_nxt  = calc_root;
            rd_ch_nxt = 1'b1;
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_PEND: begin
        if (slot_free) begin
          out_data_nxt.rms_first  = twr_pkg::OUT_W'(res0_r);
          out_data_nxt.rms_second = twr_pkg::OUT_W'(res1_r);
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dc_r        <= twr_pkg::DC_RESET;
      pos0_r      <= '0;
      pos1_r      <= '0;
      full0_r     <= 1'b0;
      full1_r     <= 1'b0;
      sum0_r      <= '0;
      sum1_r      <= '0;
      out_valid_r <= 1'b0;
      rd_ch_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dc_r        <= dc_nxt;
      pos0_r      <= pos0_nxt;
      pos1_r      <= pos1_nxt;
      full0_r     <= full0_nxt;
      full1_r     <= full1_nxt;
      sum0_r      <= sum0_nxt;
      sum1_r      <= sum1_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ch_r     <= rd_ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    sq_r       <= sq_nxt;
    res0_r     <= res0_nxt;
    res1_r     <= res1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_leaves_idle: assert property (
    @(posedge clk) disable iff (!rst_n) accept |=> state_r != S_IDLE
  ) else $error("accepted item did not start work");

  a_done_while_waiting: assert property (
    @(posedge clk) disable iff (!rst_n) calc_done |-> state_r == S_WAIT
  ) else $error("divide/root unit finished outside the wait state");

  a_pos_in_window: assert property (
    @(posedge clk) disable iff (!rst_n)
      {1'b0, pos0_r} < twr_pkg::ADDR_W'(twr_pkg::WINDOW)
  ) else $error("first channel write index beyond window");

  a_full_stays: assert property (
    @(posedge clk) disable iff (!rst_n) full0_r && full1_r |=> full0_r && full1_r
  ) else $error("filled flag dropped");

endmodule
